FILE: rtl/z_ordered_tile_hit_stack_macros.svh
// ----------------------------------------------------------------------------
// z-ordered tile hit stack assertion macros
// checks of the stack's own logic, removed for synthesis
// ----------------------------------------------------------------------------
`ifndef Z_ORDERED_TILE_HIT_STACK_MACROS_SVH
`define Z_ORDERED_TILE_HIT_STACK_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define ZOTHS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("zoths assertion failed");
// antecedent implies consequent in the next cycle
`define ZOTHS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("zoths assertion failed");
`else
`define ZOTHS_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ZOTHS_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/zoths_pkg.sv
// ----------------------------------------------------------------------------
// zoths_pkg
// shared types and codes of the z-ordered tile hit stack
// ----------------------------------------------------------------------------
package zoths_pkg;

  localparam int DEFAULT_MAX_TILES = 32;
  localparam logic [23:0] HIGHLIGHT_RESET = 24'hFFFF00;

  localparam logic [3:0] MODE_ADD_BACK   = 4'd0;
  localparam logic [3:0] MODE_ADD_FRONT  = 4'd1;
  localparam logic [3:0] MODE_HIGHLIGHT  = 4'd2;
  localparam logic [3:0] MODE_RAISE      = 4'd3;
  localparam logic [3:0] MODE_LOWER      = 4'd4;
  localparam logic [3:0] MODE_REMOVE     = 4'd5;
  localparam logic [3:0] MODE_REMOVE_ALL = 4'd6;
  localparam logic [3:0] MODE_MERGE      = 4'd7;
  localparam logic [3:0] MODE_CLEAR      = 4'd8;
  localparam logic [3:0] MODE_DUMP       = 4'd9;

  localparam logic [1:0] STATUS_DONE = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_FULL = 2'd2;

  typedef struct packed {
    logic [11:0] left;
    logic [11:0] top;
    logic [12:0] width;
    logic [12:0] height;
    logic [23:0] color;
  } tile_t;

  // what every cell does in a cycle, qualified by its own position
  typedef enum logic [2:0] {
    K_NONE,
    K_LOAD,   // cell at lo takes the tile
    K_COLOR,  // cell at lo takes the tile's colour
    K_RAISE,  // cell 0 takes the tile, cells 1..lo take their front neighbour
    K_LOWER   // cells lo..hi-1 take their back neighbour, cell hi takes the tile
  } cell_kind_t;

  typedef struct packed {
    cell_kind_t kind;
    tile_t      tile;
  } cell_cmd_t;

endpackage

FILE: rtl/zoths_cell.sv
// ----------------------------------------------------------------------------
// zoths_cell
// one stack slot: holds a tile, tests it against the query point, shifts
// ----------------------------------------------------------------------------
module zoths_cell #(
  parameter int IDX = 0,
  parameter int CW  = 6
) (
  input  logic                clk,
  input  zoths_pkg::cell_cmd_t cmd,
  input  logic [CW-1:0]       lo,
  input  logic [CW-1:0]       hi,
  input  zoths_pkg::tile_t    prev_tile,
  input  zoths_pkg::tile_t    next_tile,
  input  logic [11:0]         qx,
  input  logic [11:0]         qy,
  output zoths_pkg::tile_t    tile,
  output logic                hit
);

  localparam logic [CW-1:0] MY = CW'(IDX);

  logic [13:0] right_edge;
  logic [13:0] bottom_edge;

  // half-open box test
  assign right_edge  = {2'b00, tile.left} + {1'b0, tile.width};
  assign bottom_edge = {2'b00, tile.top} + {1'b0, tile.height};
  assign hit = (tile.left <= qx) && ({2'b00, qx} < right_edge) &&
               (tile.top <= qy) && ({2'b00, qy} < bottom_edge);

  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      zoths_pkg::K_LOAD: begin
        if (MY == lo) tile <= cmd.tile;
      end
      zoths_pkg::K_COLOR: begin
        if (MY == lo) tile.color <= cmd.tile.color;
      end
      zoths_pkg::K_RAISE: begin
        if (MY == '0) tile <= cmd.tile;
        else if (MY <= lo) tile <= prev_tile;
      end
      zoths_pkg::K_LOWER: begin
        if (MY == hi) tile <= cmd.tile;
        else if (MY >= lo && MY < hi) tile <= next_tile;
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/z_ordered_tile_hit_stack.sv
// ----------------------------------------------------------------------------
// z_ordered_tile_hit_stack
// z-ordered rectangle stack with point hit test, edit commands and dump
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Results appear for
// exactly one cycle with result_valid high and cannot be held off. Adds answer
// from the add state; clear, an unknown mode and a dump of an empty stack
// answer straight from idle. Point commands walk the row of cells from the
// front, one slot a cycle, up to the frontmost hit tile (or up to the tile
// count on a miss). Remove all and merge walk the whole row, deleting each hit
// tile and looking again at the same slot; a merge that deleted any tiles
// then places the merged tile in a further step. A dump enters its dump state
// and then streams one beat a cycle, back to front, one per tile.
// ----------------------------------------------------------------------------
`include "z_ordered_tile_hit_stack_macros.svh"

module z_ordered_tile_hit_stack #(
  parameter int MAX_TILES = zoths_pkg::DEFAULT_MAX_TILES
) (
  input  logic        clk,
  input  logic        rst,
  // command beat
  input  logic        start,
  output logic        busy,
  input  logic [3:0]  mode,
  input  logic [11:0] pos_x,
  input  logic [11:0] pos_y,
  input  logic [11:0] size_width,
  input  logic [11:0] size_height,
  input  logic [23:0] color_in,
  // highlight colour register
  input  logic        highlight_color_valid,
  output logic        highlight_color_ready,
  input  logic [23:0] highlight_color,
  // result beats
  output logic        result_valid,
  output logic [1:0]  status,
  output logic [5:0]  removed_count,
  output logic [11:0] tile_x,
  output logic [11:0] tile_y,
  output logic [12:0] tile_width,
  output logic [12:0] tile_height,
  output logic [23:0] tile_color,
  output logic        last
);

  localparam int IW = $clog2(MAX_TILES);
  localparam int CW = $clog2(MAX_TILES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TILES);
  localparam logic [CW-1:0] BACK_SLOT  = CW'(MAX_TILES - 1);

  typedef enum logic [2:0] {S_IDLE, S_ADD, S_FIND, S_PLACE, S_DUMP} state_t;

  state_t state;
  logic [CW-1:0] count;   // tiles held
  logic [CW-1:0] idx;     // walk position
  logic [CW-1:0] n;       // tiles deleted in this remove all or merge
  logic [3:0]    cmd_mode;
  logic [11:0]   qx, qy, new_w, new_h;
  logic [23:0]   new_color;
  logic [23:0]   hl_color;
  // merged bounding box, right and bottom edges one past the box
  logic [11:0]   xmin, ymin;
  logic [13:0]   xmax, ymax;
  logic [23:0]   mcolor;

  zoths_pkg::tile_t     tiles [MAX_TILES];
  logic [MAX_TILES-1:0] hits;
  zoths_pkg::cell_cmd_t ccmd;
  logic [CW-1:0]        lo, hi;
  zoths_pkg::tile_t     sel;
  logic                 found;
  logic [13:0]          sel_right, sel_bottom, mw, mh;
  zoths_pkg::tile_t     new_tile, merged_tile;

  assign busy = (state != S_IDLE);
  assign highlight_color_ready = 1'b1;

  // the row of cells, each handing tiles to its neighbours
  for (genvar g = 0; g < MAX_TILES; g++) begin : g_cell
    zoths_cell #(.IDX(g), .CW(CW)) u_cell (
      .clk       (clk),
      .cmd       (ccmd),
      .lo        (lo),
      .hi        (hi),
      .prev_tile (tiles[(g == 0) ? 0 : g - 1]),
      .next_tile (tiles[(g == MAX_TILES - 1) ? g : g + 1]),
      .qx        (qx),
      .qy        (qy),
      .tile      (tiles[g]),
      .hit       (hits[g])
    );
  end

  assign sel        = tiles[idx[IW-1:0]];
  assign found      = (idx != count) && hits[idx[IW-1:0]];
  assign sel_right  = {2'b00, sel.left} + {1'b0, sel.width};
  assign sel_bottom = {2'b00, sel.top} + {1'b0, sel.height};
  assign mw         = xmax - {2'b00, xmin};
  assign mh         = ymax - {2'b00, ymin};

  assign new_tile = '{left: qx, top: qy, width: {1'b0, new_w}, height: {1'b0, new_h},
                      color: new_color};
  // bounding sizes above the field range saturate
  assign merged_tile = '{left: xmin, top: ymin,
                         width: mw[13] ? 13'h1FFF : mw[12:0],
                         height: mh[13] ? 13'h1FFF : mh[12:0],
                         color: mcolor};

  // command broadcast to the cell row
  always_comb begin
    ccmd.kind = zoths_pkg::K_NONE;
    ccmd.tile = sel;
    lo = '0;
    hi = '0;
    unique case (state)
      S_ADD: begin
        if (count != FULL_COUNT) begin
          ccmd.tile = new_tile;
          if (cmd_mode == zoths_pkg::MODE_ADD_BACK) begin
            ccmd.kind = zoths_pkg::K_LOAD;
            lo = count;
          end else begin
            ccmd.kind = zoths_pkg::K_RAISE;
            lo = BACK_SLOT;
          end
        end
      end
      S_FIND: begin
        if (found) begin
          lo = idx;
          case (cmd_mode)
            zoths_pkg::MODE_HIGHLIGHT: begin
              ccmd.kind = zoths_pkg::K_COLOR;
              ccmd.tile.color = hl_color;
            end
            zoths_pkg::MODE_RAISE: ccmd.kind = zoths_pkg::K_RAISE;
            zoths_pkg::MODE_LOWER: begin
              ccmd.kind = zoths_pkg::K_LOWER;
              hi = count - 1'b1;
            end
            default: begin
              // delete: nobody loads, everything behind closes up
              ccmd.kind = zoths_pkg::K_LOWER;
              hi = FULL_COUNT;
            end
          endcase
        end
      end
      S_PLACE: begin
        ccmd.kind = zoths_pkg::K_RAISE;
        ccmd.tile = merged_tile;
        lo = BACK_SLOT;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    // result payload is zero unless a beat sets it
    result_valid  <= 1'b0;
    status        <= zoths_pkg::STATUS_DONE;
    removed_count <= '0;
    tile_x        <= '0;
    tile_y        <= '0;
    tile_width    <= '0;
    tile_height   <= '0;
    tile_color    <= '0;
    last          <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      count        <= '0;
      idx          <= '0;
      n            <= '0;
      hl_color     <= zoths_pkg::HIGHLIGHT_RESET;
    end else begin
      if (highlight_color_valid && highlight_color_ready) hl_color <= highlight_color;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_mode  <= mode;
            qx        <= pos_x;
            qy        <= pos_y;
            new_w     <= size_width;
            new_h     <= size_height;
            new_color <= color_in;
            idx       <= '0;
            n         <= '0;
            case (mode) inside
              zoths_pkg::MODE_ADD_BACK, zoths_pkg::MODE_ADD_FRONT: state <= S_ADD;
              zoths_pkg::MODE_HIGHLIGHT, zoths_pkg::MODE_RAISE, zoths_pkg::MODE_LOWER,
              zoths_pkg::MODE_REMOVE, zoths_pkg::MODE_REMOVE_ALL,
              zoths_pkg::MODE_MERGE: state <= S_FIND;
              zoths_pkg::MODE_DUMP: begin
                if (count == '0) begin
                  result_valid <= 1'b1;
                  status       <= zoths_pkg::STATUS_MISS;
                  last         <= 1'b1;
                end else begin
                  idx   <= count - 1'b1;
                  state <= S_DUMP;
                end
              end
              zoths_pkg::MODE_CLEAR: begin
                count        <= '0;
                result_valid <= 1'b1;
                last         <= 1'b1;
              end
              default: begin
                result_valid <= 1'b1;
                last         <= 1'b1;
              end
            endcase
          end
        end
        S_ADD: begin
          result_valid <= 1'b1;
          last         <= 1'b1;
          if (count == FULL_COUNT) status <= zoths_pkg::STATUS_FULL;
          else count <= count + 1'b1;
          state <= S_IDLE;
        end
        S_FIND: begin
          if (idx == count) begin
            // walk ended without a further hit
            if (cmd_mode == zoths_pkg::MODE_MERGE && n != '0) begin
              state <= S_PLACE;
            end else begin
              result_valid  <= 1'b1;
              last          <= 1'b1;
              removed_count <= 6'(n);
              if (cmd_mode != zoths_pkg::MODE_REMOVE_ALL) status <= zoths_pkg::STATUS_MISS;
              state <= S_IDLE;
            end
          end else if (found) begin
            case (cmd_mode) inside
              zoths_pkg::MODE_REMOVE_ALL, zoths_pkg::MODE_MERGE: begin
                // delete and look again at the same slot
                count <= count - 1'b1;
                n     <= n + 1'b1;
                if (n == '0) begin
                  mcolor <= sel.color;
                  xmin   <= sel.left;
                  ymin   <= sel.top;
                  xmax   <= sel_right;
                  ymax   <= sel_bottom;
                end else begin
                  if (sel.left < xmin) xmin <= sel.left;
                  if (sel.top < ymin) ymin <= sel.top;
                  if (sel_right > xmax) xmax <= sel_right;
                  if (sel_bottom > ymax) ymax <= sel_bottom;
                end
              end
              default: begin
                if (cmd_mode == zoths_pkg::MODE_REMOVE) count <= count - 1'b1;
                result_valid <= 1'b1;
                last         <= 1'b1;
                state        <= S_IDLE;
              end
            endcase
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_PLACE: begin
          count         <= count + 1'b1;
          result_valid  <= 1'b1;
          last          <= 1'b1;
          removed_count <= 6'(n);
          tile_x        <= merged_tile.left;
          tile_y        <= merged_tile.top;
          tile_width    <= merged_tile.width;
          tile_height   <= merged_tile.height;
          tile_color    <= merged_tile.color;
          state         <= S_IDLE;
        end
        S_DUMP: begin
          // back to front, one beat a cycle
          result_valid <= 1'b1;
          tile_x       <= sel.left;
          tile_y       <= sel.top;
          tile_width   <= sel.width;
          tile_height  <= sel.height;
          tile_color   <= sel.color;
          if (idx == '0) begin
            last  <= 1'b1;
            state <= S_IDLE;
          end else begin
            idx <= idx - 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // stack never overfills
  `ZOTHS_ASSERT_IMP(a_count_range, clk, rst, 1'b1, count <= FULL_COUNT)
  // a dump never runs on an empty stack
  `ZOTHS_ASSERT_IMP(a_dump_nonempty, clk, rst, state == S_DUMP, count != '0)
  // dump beats come without gaps until the last one
  `ZOTHS_ASSERT_NEXT(a_dump_stream, clk, rst, result_valid && !last, result_valid)
  // the final beat of a command leaves the block free
  `ZOTHS_ASSERT_IMP(a_last_frees, clk, rst, result_valid && last, !busy)

endmodule
